[rtl/lldpp_pkg.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// lldpp_pkg
// Shared types and status codes for the LLDP frame TLV parser.
// -----------------------------------------------------------------------------
package lldpp_pkg;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT       = 4'd1;
    localparam logic [3:0] ST_ETHERTYPE   = 4'd2;
    localparam logic [3:0] ST_DEST        = 4'd3;
    localparam logic [3:0] ST_HDR_LACK    = 4'd4;
    localparam logic [3:0] ST_TRUNC       = 4'd5;
    localparam logic [3:0] ST_END_SIZE    = 4'd6;
    localparam logic [3:0] ST_CH_SIZE     = 4'd7;
    localparam logic [3:0] ST_CH_DUP      = 4'd8;
    localparam logic [3:0] ST_PT_SIZE     = 4'd9;
    localparam logic [3:0] ST_PT_DUP      = 4'd10;
    localparam logic [3:0] ST_TTL_SIZE    = 4'd11;
    localparam logic [3:0] ST_TTL_DUP     = 4'd12;
    localparam logic [3:0] ST_CAPS_SIZE   = 4'd13;
    localparam logic [3:0] ST_PRIV_SHORT  = 4'd14;
    localparam logic [3:0] ST_MANDATORY   = 4'd15;

    typedef struct packed {
        logic [3:0]  status_code;
        logic [47:0] source_mac;
        logic [1:0]  dest_variant;
        logic [15:0] ttl_seconds;
        logic [7:0]  chassis_subtype;
        logic [8:0]  chassis_id_length;
        logic [7:0]  port_subtype;
        logic [8:0]  port_id_length;
        logic        has_capabilities;
        logic [15:0] system_caps;
        logic [15:0] enabled_caps;
        logic [3:0]  strings_present;
    } t_result;

    typedef struct packed {
        logic    done;
        t_result result;
    } t_core_out;

endpackage
`default_nettype wire

[rtl/lldpp_if.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// lldpp_if
// Valid/ready channels for frame bytes and parse results.
// -----------------------------------------------------------------------------
interface lldpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface lldpp_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status_code;
    logic [47:0] source_mac;
    logic [1:0]  dest_variant;
    logic [15:0] ttl_seconds;
    logic [7:0]  chassis_subtype;
    logic [8:0]  chassis_id_length;
    logic [7:0]  port_subtype;
    logic [8:0]  port_id_length;
    logic        has_capabilities;
    logic [15:0] system_caps;
    logic [15:0] enabled_caps;
    logic [3:0]  strings_present;

    modport source (
        output valid, output status_code, output source_mac, output dest_variant,
        output ttl_seconds, output chassis_subtype, output chassis_id_length,
        output port_subtype, output port_id_length, output has_capabilities,
        output system_caps, output enabled_caps, output strings_present,
        input ready
    );
    modport sink (
        input valid, input status_code, input source_mac, input dest_variant,
        input ttl_seconds, input chassis_subtype, input chassis_id_length,
        input port_subtype, input port_id_length, input has_capabilities,
        input system_caps, input enabled_caps, input strings_present,
        output ready
    );
endinterface
`default_nettype wire

[rtl/lldpp_parse_core.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// lldpp_parse_core
// Per-byte header check and TLV walk; forms the result on the last byte.
// -----------------------------------------------------------------------------
module lldpp_parse_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_frame_byte,
    input  wire logic                  i_frame_last,
    output lldpp_pkg::t_core_out       o_core
);
    import lldpp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TLV_H0,
        PH_TLV_H1,
        PH_VALUE,
        PH_DONE,
        PH_ERROR
    } t_phase;

    localparam logic [6:0] TLV_END      = 7'd0;
    localparam logic [6:0] TLV_CHASSIS  = 7'd1;
    localparam logic [6:0] TLV_PORT     = 7'd2;
    localparam logic [6:0] TLV_TTL      = 7'd3;
    localparam logic [6:0] TLV_PORT_DSC = 7'd4;
    localparam logic [6:0] TLV_SYS_NAME = 7'd5;
    localparam logic [6:0] TLV_SYS_DSC  = 7'd6;
    localparam logic [6:0] TLV_CAPS     = 7'd7;
    localparam logic [6:0] TLV_PRIVATE  = 7'd127;

    localparam logic [3:0]  HDR_LAST  = 4'd13;
    localparam logic [15:0] ETH_LLDP  = 16'h88cc;
    localparam logic [2:0]  IDX_SAT   = 3'd4;

    function automatic logic [7:0] dest_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h01;
            3'd1:    v = 8'h80;
            3'd2:    v = 8'hc2;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // OUI 00:00:5E, subtype 01
    function automatic logic [7:0] mud_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd2:    v = 8'h5e;
            2'd3:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_hdr_cnt,  n_hdr_cnt;
    logic [6:0]  r_tlv_type, n_tlv_type;
    logic [8:0]  r_tlv_rem,  n_tlv_rem;
    logic [2:0]  r_val_idx,  n_val_idx;
    logic [15:0] r_eth,      n_eth;
    logic [47:0] r_src_mac,  n_src_mac;
    logic        r_dest_bad, n_dest_bad;
    logic [1:0]  r_dest_var, n_dest_var;
    logic [3:0]  r_seen,     n_seen;
    logic [15:0] r_ttl,      n_ttl;
    logic [7:0]  r_ch_sub,   n_ch_sub;
    logic [8:0]  r_ch_len,   n_ch_len;
    logic [7:0]  r_pt_sub,   n_pt_sub;
    logic [8:0]  r_pt_len,   n_pt_len;
    logic [15:0] r_sys_caps, n_sys_caps;
    logic [15:0] r_en_caps,  n_en_caps;
    logic [3:0]  r_str,      n_str;
    logic [2:0]  r_trk,      n_trk;
    logic        r_mud,      n_mud;
    logic [3:0]  r_err,      n_err;

    logic [8:0]  tlv_len;
    logic        fin;
    logic        str_ok;
    logic        frame_end;
    t_result     res;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_tlv_type = r_tlv_type;
        n_tlv_rem  = r_tlv_rem;
        n_val_idx  = r_val_idx;
        n_eth      = r_eth;
        n_src_mac  = r_src_mac;
        n_dest_bad = r_dest_bad;
        n_dest_var = r_dest_var;
        n_seen     = r_seen;
        n_ttl      = r_ttl;
        n_ch_sub   = r_ch_sub;
        n_ch_len   = r_ch_len;
        n_pt_sub   = r_pt_sub;
        n_pt_len   = r_pt_len;
        n_sys_caps = r_sys_caps;
        n_en_caps  = r_en_caps;
        n_str      = r_str;
        n_trk      = r_trk;
        n_mud      = r_mud;
        n_err      = r_err;
        tlv_len    = {r_tlv_rem[8], i_frame_byte};
        fin        = 1'b0;
        str_ok     = 1'b0;

        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_cnt < 4'd5) begin
                        if (i_frame_byte != dest_byte(r_hdr_cnt[2:0])) begin
                            n_dest_bad = 1'b1;
                        end
                    end else if (r_hdr_cnt == 4'd5) begin
                        case (i_frame_byte)
                            8'h00:   n_dest_var = 2'd0;
                            8'h03:   n_dest_var = 2'd1;
                            8'h0e:   n_dest_var = 2'd2;
                            default: n_dest_bad = 1'b1;
                        endcase
                    end else if (r_hdr_cnt < 4'd12) begin
                        n_src_mac = {r_src_mac[39:0], i_frame_byte};
                    end else begin
                        n_eth = {r_eth[7:0], i_frame_byte};
                    end
                    n_hdr_cnt = r_hdr_cnt + 4'd1;
                    if (r_hdr_cnt == HDR_LAST) begin
                        if (n_eth != ETH_LLDP) begin
                            n_err   = ST_ETHERTYPE;
                            n_phase = PH_ERROR;
                        end else if (n_dest_bad) begin
                            n_err   = ST_DEST;
                            n_phase = PH_ERROR;
                        end else begin
                            n_phase = PH_TLV_H0;
                        end
                    end
                end
                PH_TLV_H0: begin
                    n_tlv_type = i_frame_byte[7:1];
                    n_tlv_rem  = {i_frame_byte[0], 8'h00};
                    n_phase    = PH_TLV_H1;
                end
                PH_TLV_H1: begin
                    n_tlv_rem = tlv_len;
                    n_trk     = 3'b000;
                    n_mud     = 1'b1;
                    n_val_idx = 3'd0;
                    n_err     = ST_OK;
                    unique case (r_tlv_type)
                        TLV_END: begin
                            if (tlv_len != 9'd0) n_err = ST_END_SIZE;
                        end
                        TLV_CHASSIS: begin
                            if (tlv_len < 9'd2 || tlv_len > 9'd256) begin
                                n_err = ST_CH_SIZE;
                            end else if (r_seen[0]) begin
                                n_err = ST_CH_DUP;
                            end else begin
                                n_seen[0] = 1'b1;
                                n_ch_len  = tlv_len;
                            end
                        end
                        TLV_PORT: begin
                            if (tlv_len < 9'd2 || tlv_len > 9'd256) begin
                                n_err = ST_PT_SIZE;
                            end else if (r_seen[1]) begin
                                n_err = ST_PT_DUP;
                            end else begin
                                n_seen[1] = 1'b1;
                                n_pt_len  = tlv_len;
                            end
                        end
                        TLV_TTL: begin
                            if (tlv_len != 9'd2) begin
                                n_err = ST_TTL_SIZE;
                            end else if (r_seen[2]) begin
                                n_err = ST_TTL_DUP;
                            end else begin
                                n_seen[2] = 1'b1;
                            end
                        end
                        TLV_CAPS: begin
                            if (tlv_len != 9'd4) n_err = ST_CAPS_SIZE;
                            else n_seen[3] = 1'b1;
                        end
                        TLV_PRIVATE: begin
                            if (tlv_len < 9'd4) n_err = ST_PRIV_SHORT;
                        end
                        default: ;
                    endcase
                    if (tlv_len == 9'd0) fin = 1'b1;
                    else n_phase = PH_VALUE;
                end
                PH_VALUE: begin
                    if (r_err == ST_OK) begin
                        case (r_tlv_type) inside
                            TLV_CHASSIS: begin
                                if (r_val_idx == 3'd0) n_ch_sub = i_frame_byte;
                            end
                            TLV_PORT: begin
                                if (r_val_idx == 3'd0) n_pt_sub = i_frame_byte;
                            end
                            TLV_TTL: begin
                                if (r_val_idx == 3'd0) n_ttl[15:8] = i_frame_byte;
                                else if (r_val_idx == 3'd1) n_ttl[7:0] = i_frame_byte;
                            end
                            TLV_CAPS: begin
                                case (r_val_idx)
                                    3'd0:    n_sys_caps[15:8] = i_frame_byte;
                                    3'd1:    n_sys_caps[7:0]  = i_frame_byte;
                                    3'd2:    n_en_caps[15:8]  = i_frame_byte;
                                    3'd3:    n_en_caps[7:0]   = i_frame_byte;
                                    default: ;
                                endcase
                            end
                            TLV_PORT_DSC, TLV_SYS_NAME, TLV_SYS_DSC, TLV_PRIVATE: begin
                                if (r_tlv_type == TLV_PRIVATE && r_val_idx < IDX_SAT) begin
                                    if (i_frame_byte != mud_byte(r_val_idx[1:0])) begin
                                        n_mud = 1'b0;
                                    end
                                end else if (i_frame_byte == 8'h00) begin
                                    n_trk[1] = 1'b1;
                                end else begin
                                    // nonzero after a NUL spoils the string
                                    if (r_trk[1]) n_trk[2] = 1'b1;
                                    n_trk[0] = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (r_val_idx < IDX_SAT) n_val_idx = r_val_idx + 3'd1;
                    n_tlv_rem = r_tlv_rem - 9'd1;
                    if (n_tlv_rem == 9'd0) fin = 1'b1;
                end
                default: ;
            endcase

            if (fin) begin
                str_ok = n_trk[0] && !n_trk[2];
                if (n_err != ST_OK) begin
                    n_phase = PH_ERROR;
                end else if (r_tlv_type == TLV_END) begin
                    n_phase = PH_DONE;
                end else begin
                    if (str_ok) begin
                        case (r_tlv_type)
                            TLV_PORT_DSC: n_str[0] = 1'b1;
                            TLV_SYS_NAME: n_str[1] = 1'b1;
                            TLV_SYS_DSC:  n_str[2] = 1'b1;
                            TLV_PRIVATE:  if (n_mud) n_str[3] = 1'b1;
                            default: ;
                        endcase
                    end
                    n_phase = PH_TLV_H0;
                end
            end
        end
    end

    always_comb begin
        res = '0;
        unique case (n_phase)
            PH_HEADER:            res.status_code = ST_SHORT;
            PH_TLV_H0, PH_TLV_H1: res.status_code = ST_HDR_LACK;
            PH_VALUE:             res.status_code = ST_TRUNC;
            PH_DONE:              res.status_code = (n_seen[2:0] == 3'b111) ? ST_OK
                                                                          : ST_MANDATORY;
            default:              res.status_code = n_err;
        endcase
        if (res.status_code == ST_OK) begin
            res.source_mac        = n_src_mac;
            res.dest_variant      = n_dest_var;
            res.ttl_seconds       = n_ttl;
            res.chassis_subtype   = n_ch_sub;
            res.chassis_id_length = n_ch_len;
            res.port_subtype      = n_pt_sub;
            res.port_id_length    = n_pt_len;
            res.has_capabilities  = n_seen[3];
            res.system_caps       = n_sys_caps;
            res.enabled_caps      = n_en_caps;
            res.strings_present   = n_str;
        end
    end

    assign frame_end     = i_accept && i_frame_last;
    assign o_core.done   = frame_end;
    assign o_core.result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || frame_end) begin
            r_phase    <= PH_HEADER;
            r_hdr_cnt  <= '0;
            r_tlv_type <= '0;
            r_tlv_rem  <= '0;
            r_val_idx  <= '0;
            r_eth      <= '0;
            r_src_mac  <= '0;
            r_dest_bad <= 1'b0;
            r_dest_var <= '0;
            r_seen     <= '0;
            r_ttl      <= '0;
            r_ch_sub   <= '0;
            r_ch_len   <= '0;
            r_pt_sub   <= '0;
            r_pt_len   <= '0;
            r_sys_caps <= '0;
            r_en_caps  <= '0;
            r_str      <= '0;
            r_trk      <= '0;
            r_mud      <= 1'b0;
            r_err      <= ST_OK;
        end else begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_tlv_type <= n_tlv_type;
            r_tlv_rem  <= n_tlv_rem;
            r_val_idx  <= n_val_idx;
            r_eth      <= n_eth;
            r_src_mac  <= n_src_mac;
            r_dest_bad <= n_dest_bad;
            r_dest_var <= n_dest_var;
            r_seen     <= n_seen;
            r_ttl      <= n_ttl;
            r_ch_sub   <= n_ch_sub;
            r_ch_len   <= n_ch_len;
            r_pt_sub   <= n_pt_sub;
            r_pt_len   <= n_pt_len;
            r_sys_caps <= n_sys_caps;
            r_en_caps  <= n_en_caps;
            r_str      <= n_str;
            r_trk      <= n_trk;
            r_mud      <= n_mud;
            r_err      <= n_err;
        end
    end

endmodule
`default_nettype wire

[rtl/lldp_frame_tlv_parser_unit.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// lldp_frame_tlv_parser_unit
// LLDP frame parser: header check, TLV walk, one result per frame.
// -----------------------------------------------------------------------------
// Channel    Dir  Payload                                   Transaction
// i_frame    in   frame_byte, frame_last                    one frame byte
// o_result   out  status_code .. strings_present            one parsed frame
//
// One byte per clock is accepted while ready is high; parser state updates in
// the accept cycle. The result of a frame is registered into the output entry,
// or into the second entry while the output is held. This two-entry buffer
// lets bytes keep flowing while a result waits; ready drops only when both entries are full.
// Synchronous active-low reset clears parser state and the output buffer.
// -----------------------------------------------------------------------------
module lldp_frame_tlv_parser_unit (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lldpp_byte_if.sink    i_frame,
    lldpp_res_if.source   o_result
);
    import lldpp_pkg::*;

    logic      accept;
    t_core_out core_out;

    logic      r_res_valid;
    t_result   r_res;
    logic      r_skd_valid;
    t_result   r_skd;

    assign i_frame.ready = !r_skd_valid;
    assign accept        = i_frame.valid && !r_skd_valid;

    lldpp_parse_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_frame_byte (i_frame.frame_byte),
        .i_frame_last (i_frame.frame_last),
        .o_core       (core_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (!r_res_valid || o_result.ready) begin
                if (r_skd_valid) begin
                    r_res       <= r_skd;
                    r_res_valid <= 1'b1;
                    r_skd_valid <= 1'b0;
                end else begin
                    r_res       <= core_out.result;
                    r_res_valid <= core_out.done;
                end
            end else if (core_out.done) begin
                r_skd       <= core_out.result;
                r_skd_valid <= 1'b1;
            end
        end
    end

    assign o_result.valid             = r_res_valid;
    assign o_result.status_code       = r_res.status_code;
    assign o_result.source_mac        = r_res.source_mac;
    assign o_result.dest_variant      = r_res.dest_variant;
    assign o_result.ttl_seconds       = r_res.ttl_seconds;
    assign o_result.chassis_subtype   = r_res.chassis_subtype;
    assign o_result.chassis_id_length = r_res.chassis_id_length;
    assign o_result.port_subtype      = r_res.port_subtype;
    assign o_result.port_id_length    = r_res.port_id_length;
    assign o_result.has_capabilities  = r_res.has_capabilities;
    assign o_result.system_caps       = r_res.system_caps;
    assign o_result.enabled_caps      = r_res.enabled_caps;
    assign o_result.strings_present   = r_res.strings_present;

endmodule
`default_nettype wire

[tb/lldp_frame_tlv_parser_unit_tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lldp_frame_tlv_parser_unit_tb
// Self-checking bench for the LLDP frame parser. Whole frames are built as
// byte lists (directed corner frames first, then random frames that are
// mostly well formed), streamed one byte per transaction with random gaps,
// and the single result per frame is checked against a cycle-free model
// kept in a small scoreboard. The result side stalls at random, and once
// holds off long enough to back the parser up.
// -----------------------------------------------------------------------------
module lldp_frame_tlv_parser_unit_tb;
    import lldpp_pkg::*;

    localparam int CLK_HALF          = 6;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int DRAIN_LIMIT       = 20000;
    localparam int TAIL_CYCLES       = 16;
    localparam int MAX_FRAME_BYTES   = 2048;
    localparam int LONG_FRAME_BYTES  = 2100;
    localparam int RAND_BYTE_TARGET  = 1050;
    localparam int RAND_FRAME_TARGET = 40;
    localparam int HOLD_AT_RESULT    = 5;
    localparam int HOLD_CYCLES       = 500;

    localparam logic [15:0] ETH_LLDP    = 16'h88cc;
    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [39:0] DST_PREFIX  = 40'h0180c20000;
    localparam logic [31:0] MUD_PREFIX  = 32'h00005e01;
    localparam logic [7:0]  DST_TAIL_00 = 8'h00;
    localparam logic [7:0]  DST_TAIL_03 = 8'h03;
    localparam logic [7:0]  DST_TAIL_0E = 8'h0e;

    localparam logic [1:0] DEST_VAR_00 = 2'd0;
    localparam logic [1:0] DEST_VAR_03 = 2'd1;
    localparam logic [1:0] DEST_VAR_0E = 2'd2;

    localparam logic [6:0] TLV_END       = 7'd0;
    localparam logic [6:0] TLV_CHASSIS   = 7'd1;
    localparam logic [6:0] TLV_PORT      = 7'd2;
    localparam logic [6:0] TLV_TTL       = 7'd3;
    localparam logic [6:0] TLV_PORT_DESC = 7'd4;
    localparam logic [6:0] TLV_SYS_NAME  = 7'd5;
    localparam logic [6:0] TLV_SYS_DESC  = 7'd6;
    localparam logic [6:0] TLV_CAPS      = 7'd7;
    localparam logic [6:0] TLV_PRIVATE   = 7'd127;

    typedef enum logic [2:0] {
        PH_HDR, PH_TLV_TYPE, PH_TLV_LEN, PH_VALUE, PH_DONE, PH_ERR
    } parse_phase_e;

    typedef enum int {
        STR_PLAIN, STR_TRAIL_NUL, STR_INNER_NUL, STR_ALL_NUL, STR_ANY
    } str_kind_e;

    // Frame parse model plus the queue of results still owed by the DUT
    class lldp_scoreboard;
        t_result      expected_q[$];
        int           errors = 0;
        parse_phase_e phase;
        int           offset;
        int           val_idx;
        logic [6:0]   tlv_type;
        logic [8:0]   tlv_rem;
        logic [15:0]  etype;
        logic [47:0]  smac;
        logic [1:0]   dvar;
        logic         dbad;
        logic [3:0]   seen;      // chassis, port, ttl, caps
        logic [3:0]   err;
        logic         str_nz, str_nul, str_broken;
        logic         mud_ok;
        t_result      acc;

        function void clear_frame();
            phase      = PH_HDR;
            offset     = 0;
            val_idx    = 0;
            tlv_type   = '0;
            tlv_rem    = '0;
            etype      = '0;
            smac       = '0;
            dvar       = DEST_VAR_00;
            dbad       = 1'b0;
            seen       = '0;
            err        = ST_OK;
            str_nz     = 1'b0;
            str_nul    = 1'b0;
            str_broken = 1'b0;
            mud_ok     = 1'b0;
            acc        = '0;
        endfunction

        function void string_byte(logic [7:0] b);
            if (b == 8'h00) begin
                str_nul = 1'b1;
            end else begin
                if (str_nul) str_broken = 1'b1;
                str_nz = 1'b1;
            end
        endfunction

        function void header_byte(logic [7:0] b);
            if (offset < 5) begin
                if (b != DST_PREFIX[39 - 8*offset -: 8]) dbad = 1'b1;
            end else if (offset == 5) begin
                case (b)
                    DST_TAIL_00: dvar = DEST_VAR_00;
                    DST_TAIL_03: dvar = DEST_VAR_03;
                    DST_TAIL_0E: dvar = DEST_VAR_0E;
                    default:     dbad = 1'b1;
                endcase
            end else if (offset < 12) begin
                smac = {smac[39:0], b};
            end else begin
                etype = {etype[7:0], b};
            end
            if (offset == 13) begin
                if (etype != ETH_LLDP) begin
                    err   = ST_ETHERTYPE;
                    phase = PH_ERR;
                end else if (dbad) begin
                    err   = ST_DEST;
                    phase = PH_ERR;
                end else begin
                    phase = PH_TLV_TYPE;
                end
            end
        endfunction

        function void close_tlv();
            logic valid_str;
            valid_str = str_nz && !str_broken;
            if (err != ST_OK) begin
                phase = PH_ERR;
                return;
            end
            if (tlv_type == TLV_END) begin
                phase = PH_DONE;
                return;
            end
            if (tlv_type inside {TLV_PORT_DESC, TLV_SYS_NAME, TLV_SYS_DESC} && valid_str)
                acc.strings_present[tlv_type - TLV_PORT_DESC] = 1'b1;
            if (tlv_type == TLV_PRIVATE && mud_ok && valid_str)
                acc.strings_present[3] = 1'b1;
            phase = PH_TLV_TYPE;
        endfunction

        function void open_tlv();
            logic [3:0] e;
            e          = ST_OK;
            str_nz     = 1'b0;
            str_nul    = 1'b0;
            str_broken = 1'b0;
            mud_ok     = 1'b1;
            val_idx    = 0;
            case (tlv_type)
                TLV_END: if (tlv_rem != 0) e = ST_END_SIZE;
                TLV_CHASSIS: begin
                    if (tlv_rem < 2 || tlv_rem > 256) e = ST_CH_SIZE;
                    else if (seen[0]) e = ST_CH_DUP;
                    else begin
                        seen[0] = 1'b1;
                        acc.chassis_id_length = tlv_rem;
                    end
                end
                TLV_PORT: begin
                    if (tlv_rem < 2 || tlv_rem > 256) e = ST_PT_SIZE;
                    else if (seen[1]) e = ST_PT_DUP;
                    else begin
                        seen[1] = 1'b1;
                        acc.port_id_length = tlv_rem;
                    end
                end
                TLV_TTL: begin
                    if (tlv_rem != 2) e = ST_TTL_SIZE;
                    else if (seen[2]) e = ST_TTL_DUP;
                    else seen[2] = 1'b1;
                end
                TLV_CAPS: begin
                    if (tlv_rem != 4) e = ST_CAPS_SIZE;
                    else seen[3] = 1'b1;
                end
                TLV_PRIVATE: if (tlv_rem < 4) e = ST_PRIV_SHORT;
                default: ;
            endcase
            err = e;
            if (tlv_rem == 0) close_tlv();
            else phase = PH_VALUE;
        endfunction

        function void value_byte(logic [7:0] b);
            if (err == ST_OK) begin
                case (tlv_type)
                    TLV_CHASSIS: if (val_idx == 0) acc.chassis_subtype = b;
                    TLV_PORT:    if (val_idx == 0) acc.port_subtype = b;
                    TLV_TTL: begin
                        if (val_idx == 0) acc.ttl_seconds[15:8] = b;
                        else if (val_idx == 1) acc.ttl_seconds[7:0] = b;
                    end
                    TLV_PORT_DESC, TLV_SYS_NAME, TLV_SYS_DESC: string_byte(b);
                    TLV_CAPS: begin
                        case (val_idx)
                            0: acc.system_caps[15:8]  = b;
                            1: acc.system_caps[7:0]   = b;
                            2: acc.enabled_caps[15:8] = b;
                            3: acc.enabled_caps[7:0]  = b;
                            default: ;
                        endcase
                    end
                    TLV_PRIVATE: begin
                        if (val_idx < 4) begin
                            if (b != MUD_PREFIX[31 - 8*val_idx -: 8]) mud_ok = 1'b0;
                        end else begin
                            string_byte(b);
                        end
                    end
                    default: ;
                endcase
            end
            val_idx++;
            tlv_rem--;
            if (tlv_rem == 0) close_tlv();
        endfunction

        // One accepted frame byte; the closing byte queues the frame's result
        function void note_byte(logic [7:0] b, logic last);
            t_result    r;
            logic [3:0] st;
            case (phase)
                PH_HDR:      header_byte(b);
                PH_TLV_TYPE: begin
                    tlv_type = b[7:1];
                    tlv_rem  = {b[0], 8'h00};
                    phase    = PH_TLV_LEN;
                end
                PH_TLV_LEN: begin
                    tlv_rem[7:0] = b;
                    open_tlv();
                end
                PH_VALUE:    value_byte(b);
                default: ;
            endcase
            if (offset < MAX_FRAME_BYTES) offset++;
            if (!last) return;
            case (phase)
                PH_HDR:                  st = ST_SHORT;
                PH_TLV_TYPE, PH_TLV_LEN: st = ST_HDR_LACK;
                PH_VALUE:                st = ST_TRUNC;
                PH_DONE:                 st = (seen[2:0] == 3'b111) ? ST_OK : ST_MANDATORY;
                default:                 st = err;
            endcase
            r = '0;
            r.status_code = st;
            if (st == ST_OK) begin
                r = acc;
                r.status_code      = ST_OK;
                r.source_mac       = smac;
                r.dest_variant     = dvar;
                r.has_capabilities = seen[3];
            end
            expected_q.push_back(r);
            clear_frame();
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("result with no frame outstanding, status %0d", got.status_code);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status_code", want.status_code, got.status_code);
            compare_field("source_mac", want.source_mac, got.source_mac);
            compare_field("dest_variant", want.dest_variant, got.dest_variant);
            compare_field("ttl_seconds", want.ttl_seconds, got.ttl_seconds);
            compare_field("chassis_subtype", want.chassis_subtype, got.chassis_subtype);
            compare_field("chassis_id_length", want.chassis_id_length, got.chassis_id_length);
            compare_field("port_subtype", want.port_subtype, got.port_subtype);
            compare_field("port_id_length", want.port_id_length, got.port_id_length);
            compare_field("has_capabilities", want.has_capabilities, got.has_capabilities);
            compare_field("system_caps", want.system_caps, got.system_caps);
            compare_field("enabled_caps", want.enabled_caps, got.enabled_caps);
            compare_field("strings_present", want.strings_present, got.strings_present);
        endfunction

        function void report_leftovers();
            foreach (expected_q[i]) begin
                $error("frame result never delivered, expected status %0d",
                       expected_q[i].status_code);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;

    lldpp_byte_if frame_ch ();
    lldpp_res_if  result_ch ();

    lldp_frame_tlv_parser_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    lldp_scoreboard sb;
    logic [7:0]     frm[$];     // frame under construction
    logic           calm_tx;

    // ---------------- frame construction ----------------

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic void put_header(logic [1:0] variant, logic [47:0] mac,
                                       logic [15:0] eth);
        int i;
        for (i = 0; i < 5; i++) frm.push_back(DST_PREFIX[39 - 8*i -: 8]);
        case (variant)
            DEST_VAR_00: frm.push_back(DST_TAIL_00);
            DEST_VAR_03: frm.push_back(DST_TAIL_03);
            default:     frm.push_back(DST_TAIL_0E);
        endcase
        for (i = 0; i < 6; i++) frm.push_back(mac[47 - 8*i -: 8]);
        frm.push_back(eth[15:8]);
        frm.push_back(eth[7:0]);
    endfunction

    function automatic void put_tlv_head(logic [6:0] typ, int len);
        logic [8:0] l;
        l = len[8:0];
        frm.push_back({typ, l[8]});
        frm.push_back(l[7:0]);
    endfunction

    function automatic void put_random(int n);
        repeat (n) frm.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_string(int n, str_kind_e kind);
        int i;
        for (i = 0; i < n; i++) begin
            case (kind)
                STR_PLAIN:     frm.push_back(8'($urandom_range(1, 255)));
                STR_TRAIL_NUL: frm.push_back((i < (n + 1) / 2) ? 8'($urandom_range(1, 255)) : 8'h00);
                STR_INNER_NUL: frm.push_back((i == n / 2 && n > 2) ? 8'h00
                                                                  : 8'($urandom_range(1, 255)));
                STR_ALL_NUL:   frm.push_back(8'h00);
                default:       frm.push_back(($urandom_range(0, 3) == 0) ? 8'h00
                                                                         : 8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    function automatic void put_tlv(logic [6:0] typ, int len);
        put_tlv_head(typ, len);
        put_random(len);
    endfunction

    function automatic void put_ttl(logic [15:0] v);
        put_tlv_head(TLV_TTL, 2);
        frm.push_back(v[15:8]);
        frm.push_back(v[7:0]);
    endfunction

    function automatic void put_caps(logic [15:0] sys, logic [15:0] en);
        put_tlv_head(TLV_CAPS, 4);
        frm.push_back(sys[15:8]);
        frm.push_back(sys[7:0]);
        frm.push_back(en[15:8]);
        frm.push_back(en[7:0]);
    endfunction

    function automatic void put_mud(int n, str_kind_e kind);
        int i;
        put_tlv_head(TLV_PRIVATE, 4 + n);
        for (i = 0; i < 4; i++) frm.push_back(MUD_PREFIX[31 - 8*i -: 8]);
        put_string(n, kind);
    endfunction

    function automatic void put_mandatory();
        put_tlv(TLV_CHASSIS, $urandom_range(2, 9));
        put_tlv(TLV_PORT, $urandom_range(2, 9));
        put_ttl(16'($urandom));
    endfunction

    function automatic void put_end();
        put_tlv_head(TLV_END, 0);
    endfunction

    function automatic void put_optional();
        int        sel;
        int        n;
        str_kind_e kind;
        sel  = $urandom_range(0, 6);
        n    = $urandom_range(0, 10);
        kind = str_kind_e'($urandom_range(0, 4));
        case (sel)
            0, 1, 2: begin
                put_tlv_head(7'(TLV_PORT_DESC + sel), n);
                put_string(n, kind);
            end
            3:       put_caps(16'($urandom), 16'($urandom));
            4:       put_mud($urandom_range(0, 8), kind);
            5:       put_tlv(TLV_PRIVATE, $urandom_range(4, 10));
            default: put_tlv(7'($urandom_range(8, 126)), $urandom_range(0, 8));
        endcase
    endfunction

    // A TLV breaking one size or duplicate rule, placed after the mandatory ones
    function automatic void put_faulty(int fault);
        int l;
        case (fault)
            0: put_tlv(TLV_CHASSIS, $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                         : $urandom_range(257, 280));
            1: put_tlv(TLV_CHASSIS, $urandom_range(2, 9));
            2: put_tlv(TLV_PORT, $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                      : $urandom_range(257, 280));
            3: put_tlv(TLV_PORT, $urandom_range(2, 9));
            4: begin
                l = $urandom_range(0, 3);
                if (l >= 2) l++;
                put_tlv(TLV_TTL, l);
            end
            5: put_ttl(16'($urandom));
            6: begin
                l = $urandom_range(0, 7);
                if (l >= 4) l++;
                put_tlv(TLV_CAPS, l);
            end
            7: put_tlv(TLV_PRIVATE, $urandom_range(0, 3));
            default: put_tlv(TLV_END, $urandom_range(1, 5));
        endcase
    endfunction

    function automatic void build_random_frame();
        int   mode, fault, n_opt, cut, i;
        logic skip_end;
        mode     = $urandom_range(0, 15);   // 0..11 well formed
        fault    = $urandom_range(0, 8);
        skip_end = (mode == 15 && fault >= 3);
        put_header(2'($urandom_range(0, 2)), rand_mac(), ETH_LLDP);
        if (mode == 15 && fault < 3) begin
            if (fault != 0) put_tlv(TLV_CHASSIS, $urandom_range(2, 9));
            if (fault != 1) put_tlv(TLV_PORT, $urandom_range(2, 9));
            if (fault != 2) put_ttl(16'($urandom));
        end else if ($urandom_range(0, 3) == 0) begin
            put_ttl(16'($urandom));
            put_tlv(TLV_PORT, $urandom_range(2, 9));
            put_tlv(TLV_CHASSIS, $urandom_range(2, 9));
        end else begin
            put_tlv(TLV_CHASSIS, ($urandom_range(0, 19) == 0) ? 256 : $urandom_range(2, 9));
            put_tlv(TLV_PORT, ($urandom_range(0, 19) == 0) ? 256 : $urandom_range(2, 9));
            put_ttl(16'($urandom));
        end
        n_opt = $urandom_range(0, 4);
        for (i = 0; i < n_opt; i++) put_optional();
        if (mode == 14) begin
            put_faulty(fault);
            if ($urandom_range(0, 1)) put_optional();
        end
        if (!skip_end) put_end();
        put_random($urandom_range(0, 4));
        if (mode == 12) begin
            cut = $urandom_range(1, frm.size());
            while (frm.size() > cut) void'(frm.pop_back());
        end
        if (mode == 13) frm[$urandom_range(0, frm.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // ---------------- driving ----------------

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_byte <= b;
        frame_ch.frame_last <= last;
        do @(posedge i_clk); while (frame_ch.ready !== 1'b1);
        sb.note_byte(b, last);
    endtask

    task automatic send_frame();
        calm_tx = ($urandom_range(0, 3) == 0);
        foreach (frm[i]) send_byte(frm[i], i == frm.size() - 1);
        frm.delete();
    endtask

    task automatic drain_results();
        int      stall;
        int      n_seen;
        logic    calm_rx;
        t_result got;
        n_seen  = 0;
        calm_rx = 1'b0;
        forever begin
            if (n_seen % 8 == 0) calm_rx = ($urandom_range(0, 2) == 0);
            stall = calm_rx ? 0 : $urandom_range(0, 7);
            // long hold-off while the sender keeps going, to fill the output buffer
            if (n_seen == HOLD_AT_RESULT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (result_ch.valid !== 1'b1);
            got.status_code       = result_ch.status_code;
            got.source_mac        = result_ch.source_mac;
            got.dest_variant      = result_ch.dest_variant;
            got.ttl_seconds       = result_ch.ttl_seconds;
            got.chassis_subtype   = result_ch.chassis_subtype;
            got.chassis_id_length = result_ch.chassis_id_length;
            got.port_subtype      = result_ch.port_subtype;
            got.port_id_length    = result_ch.port_id_length;
            got.has_capabilities  = result_ch.has_capabilities;
            got.system_caps       = result_ch.system_caps;
            got.enabled_caps      = result_ch.enabled_caps;
            got.strings_present   = result_ch.strings_present;
            sb.check(got);
            n_seen++;
        end
    endtask

    task automatic run_directed();
        int i;
        // minimal good frame, smallest ID lengths
        put_header(DEST_VAR_00, 48'h0, ETH_LLDP);
        put_tlv(TLV_CHASSIS, 2);
        put_tlv(TLV_PORT, 2);
        put_ttl(16'h0000);
        put_end();
        send_frame();
        // every optional TLV, strings valid, padding after End
        put_header(DEST_VAR_03, 48'hffff_ffff_ffff, ETH_LLDP);
        put_tlv(TLV_CHASSIS, 7);
        put_tlv(TLV_PORT, 5);
        put_ttl(16'hffff);
        put_tlv_head(TLV_PORT_DESC, 6);
        put_string(6, STR_PLAIN);
        put_tlv_head(TLV_SYS_NAME, 6);
        put_string(6, STR_TRAIL_NUL);
        put_tlv_head(TLV_SYS_DESC, 1);
        put_string(1, STR_PLAIN);
        put_caps(16'hffff, 16'hffff);
        put_mud(10, STR_PLAIN);
        put_tlv_head(TLV_PRIVATE, 8);
        frm.push_back(8'h00);
        frm.push_back(8'h80);
        frm.push_back(8'hc2);
        frm.push_back(8'h01);
        put_string(4, STR_PLAIN);
        put_tlv(7'd9, 3);
        put_end();
        put_random(3);
        send_frame();
        // largest ID lengths, capabilities given twice
        put_header(DEST_VAR_0E, rand_mac(), ETH_LLDP);
        put_tlv(TLV_CHASSIS, 256);
        put_tlv(TLV_PORT, 256);
        put_ttl(16'($urandom));
        put_caps(16'h0000, 16'h0000);
        put_caps(16'($urandom), 16'($urandom));
        put_end();
        send_frame();
        // strings that must not count; a later bad copy keeps an earlier good one
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        put_mandatory();
        put_tlv_head(TLV_PORT_DESC, 3);
        put_string(3, STR_PLAIN);
        put_tlv_head(TLV_PORT_DESC, 5);
        put_string(5, STR_INNER_NUL);
        put_tlv_head(TLV_SYS_NAME, 4);
        put_string(4, STR_ALL_NUL);
        put_tlv_head(TLV_SYS_DESC, 0);
        put_mud(3, STR_ALL_NUL);
        put_tlv_head(TLV_PRIVATE, 8);
        frm.push_back(8'h00);
        frm.push_back(8'h00);
        frm.push_back(8'h5e);
        frm.push_back(8'h02);
        put_string(4, STR_PLAIN);
        put_end();
        send_frame();
        // longest TLV: private of length 511 carrying a MUD URL
        put_header(DEST_VAR_03, rand_mac(), ETH_LLDP);
        put_mandatory();
        put_mud(507, STR_PLAIN);
        put_end();
        send_frame();
        // short frames: one byte, 13, 14 and 15 bytes
        put_random(1);
        send_frame();
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        void'(frm.pop_back());
        send_frame();
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        send_frame();
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        put_random(1);
        send_frame();
        // header faults; ethertype wins when both are wrong
        put_header(DEST_VAR_00, rand_mac(), ETH_IPV4);
        put_mandatory();
        put_end();
        send_frame();
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        frm[0] = 8'h03;
        put_mandatory();
        put_end();
        send_frame();
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        frm[5] = 8'h05;
        put_mandatory();
        put_end();
        send_frame();
        put_header(DEST_VAR_00, rand_mac(), ETH_IPV4);
        frm[3] = 8'h01;
        put_mandatory();
        put_end();
        send_frame();
        // frame ends right after a TLV
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        put_mandatory();
        send_frame();
        // truncated value, with and without a size fault pending
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        put_tlv_head(TLV_CHASSIS, 5);
        put_random(2);
        send_frame();
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        put_tlv_head(TLV_CHASSIS, 1);
        send_frame();
        // chassis size: 0, 1 and 257
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        put_tlv_head(TLV_CHASSIS, 0);
        put_mandatory();
        put_end();
        send_frame();
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        put_tlv(TLV_CHASSIS, 1);
        put_mandatory();
        put_end();
        send_frame();
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        put_tlv(TLV_CHASSIS, 257);
        put_end();
        send_frame();
        // first fault in frame order is the one reported
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        put_mandatory();
        put_tlv(TLV_CHASSIS, 3);
        put_tlv(TLV_CAPS, 5);
        put_end();
        send_frame();
        for (i = 0; i < 8; i++) begin
            put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
            put_mandatory();
            put_faulty(i + 1);
            put_end();
            send_frame();
        end
        // mandatory TLVs missing
        put_header(DEST_VAR_0E, rand_mac(), ETH_LLDP);
        put_tlv(TLV_CHASSIS, 4);
        put_tlv(TLV_PORT, 4);
        put_end();
        send_frame();
        put_header(DEST_VAR_00, rand_mac(), ETH_LLDP);
        put_tlv(7'd126, 0);
        put_tlv(TLV_PORT, 3);
        put_ttl(16'h0102);
        put_end();
        send_frame();
        // frame longer than the offset counter's range
        put_header(DEST_VAR_03, rand_mac(), ETH_LLDP);
        put_mandatory();
        put_end();
        while (frm.size() < LONG_FRAME_BYTES) frm.push_back(8'($urandom_range(0, 255)));
        send_frame();
    endtask

    initial begin
        int rnd_bytes;
        int rnd_frames;
        int wait_cycles;
        sb = new;
        sb.clear_frame();
        calm_tx             = 1'b0;
        i_rst_n             <= 1'b0;
        frame_ch.valid      <= 1'b0;
        frame_ch.frame_byte <= 8'h00;
        frame_ch.frame_last <= 1'b0;
        result_ch.ready     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_results();
        join_none
        run_directed();
        rnd_bytes  = 0;
        rnd_frames = 0;
        while (rnd_bytes < RAND_BYTE_TARGET || rnd_frames < RAND_FRAME_TARGET) begin
            build_random_frame();
            rnd_bytes += frm.size();
            rnd_frames++;
            send_frame();
        end
        frame_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (sb.expected_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.report_leftovers();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
